// ----- src/bbc_pkg.sv -----
// Shared types and status codes for the buffer cache tag manager.
package bbc_pkg;

  localparam logic [2:0] ST_HIT       = 3'd0;
  localparam logic [2:0] ST_FRESH     = 3'd1;
  localparam logic [2:0] ST_EVICT     = 3'd2;
  localparam logic [2:0] ST_EXHAUSTED = 3'd3;
  localparam logic [2:0] ST_RELEASED  = 3'd4;
  localparam logic [2:0] ST_REL_ERR   = 3'd5;
  localparam logic [2:0] ST_SATURATED = 3'd6;

  localparam logic [15:0] CNT_MAX = 16'hFFFF;

  typedef enum logic [1:0] {
    OP_HIT   = 2'd0,
    OP_REL   = 2'd1,
    OP_EVICT = 2'd2
  } op_kind_t;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_DECODE = 6'b000010,
    S_SCAN   = 6'b000100,
    S_FETCH  = 6'b001000,
    S_OP     = 6'b010000,
    S_RESP   = 6'b100000
  } state_t;

  typedef struct packed {
    logic capture;
    logic decode;
    logic scan;
    logic hit;
    logic fresh;
    logic full;
    logic evict;
    logic exec;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic is_rel;
    logic rel_bad;
    logic scan_more;
    logic pend;
    logic match;
    logic fresh_avail;
    logic list_empty;
  } sts_t;

endpackage

// ----- src/block_buffer_cache_lru_core.sv -----
// A release runs DECODE, FETCH, OP, RESP; a slot never used goes from DECODE to RESP.
// An acquire scans the slots in use, one tag a cycle, then a hit or an eviction runs
// FETCH, OP, RESP; a fresh slot or a full pool goes to RESP. Output stalls hold RESP.
// One item at a time: the next input is taken once the previous result is registered.
// The release list is a doubly linked list in memory, updated in the OP state.
// Synchronous active-low reset empties the pool at once (fill count, list head),
// with no clearing pass; memory contents are not reset.
module block_buffer_cache_lru_core #(
  parameter int SLOTS = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_command,
  input  logic [31:0] in_file_id,
  input  logic [31:0] in_block_index,
  input  logic [5:0]  in_release_slot,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [5:0]  out_slot,
  output logic [2:0]  out_status,
  output logic [15:0] out_ref_after,
  output logic [31:0] out_evicted_file,
  output logic [31:0] out_evicted_index
);

  bbc_pkg::cmd_t cmd;
  bbc_pkg::sts_t sts;

  bbc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  bbc_dpath #(.SLOTS(SLOTS)) u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_command        (in_command),
    .in_file_id        (in_file_id),
    .in_block_index    (in_block_index),
    .in_release_slot   (in_release_slot),
    .cmd               (cmd),
    .sts               (sts),
    .out_slot          (out_slot),
    .out_status        (out_status),
    .out_ref_after     (out_ref_after),
    .out_evicted_file  (out_evicted_file),
    .out_evicted_index (out_evicted_index)
  );

endmodule

// ----- src/bbc_ctrl.sv -----
// Sequencing state machine for the buffer cache tag manager.
module bbc_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  input  bbc_pkg::sts_t sts,
  output bbc_pkg::cmd_t cmd
);

  bbc_pkg::state_t state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;

  assign in_stall  = (state_r != bbc_pkg::S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      bbc_pkg::S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = bbc_pkg::S_DECODE;
        end
      end
      bbc_pkg::S_DECODE: begin
        cmd.decode = 1'b1;
        if (!sts.is_rel) state_nxt = bbc_pkg::S_SCAN;
        else if (sts.rel_bad) state_nxt = bbc_pkg::S_RESP;
        else state_nxt = bbc_pkg::S_FETCH;
      end
      bbc_pkg::S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.match) begin
          cmd.hit   = 1'b1;
          state_nxt = bbc_pkg::S_FETCH;
        end else if (!sts.pend && !sts.scan_more) begin
          // all slots in use checked, no hit
          if (sts.fresh_avail) begin
            cmd.fresh = 1'b1;
            state_nxt = bbc_pkg::S_RESP;
          end else if (sts.list_empty) begin
            cmd.full  = 1'b1;
            state_nxt = bbc_pkg::S_RESP;
          end else begin
            cmd.evict = 1'b1;
            state_nxt = bbc_pkg::S_FETCH;
          end
        end
      end
      bbc_pkg::S_FETCH: begin
        state_nxt = bbc_pkg::S_OP;
      end
      bbc_pkg::S_OP: begin
        cmd.exec  = 1'b1;
        state_nxt = bbc_pkg::S_RESP;
      end
      bbc_pkg::S_RESP: begin
        if (!out_valid_r || !out_stall) begin
          cmd.out_load = 1'b1;
          state_nxt    = bbc_pkg::S_IDLE;
        end
      end
      default: state_nxt = bbc_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
    if (cmd.out_load) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bbc_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ----- src/bbc_dpath.sv -----
// Tag, count and release-list storage with lookup and update datapath.
module bbc_dpath #(
  parameter int SLOTS = 64
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_command,
  input  logic [31:0]   in_file_id,
  input  logic [31:0]   in_block_index,
  input  logic [5:0]    in_release_slot,
  input  bbc_pkg::cmd_t cmd,
  output bbc_pkg::sts_t sts,
  output logic [5:0]    out_slot,
  output logic [2:0]    out_status,
  output logic [15:0]   out_ref_after,
  output logic [31:0]   out_evicted_file,
  output logic [31:0]   out_evicted_index
);

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = IW + 1;
  localparam int WW = IW + 7;

  // slot storage; tag and count entries below the fill count are always written
  logic [31:0] tag_file_mem  [SLOTS];
  logic [31:0] tag_block_mem [SLOTS];
  logic [15:0] ref_mem       [SLOTS];
  logic [IW-1:0] prev_mem    [SLOTS];
  logic [IW-1:0] next_mem    [SLOTS];

  logic          cmd_r;
  logic [31:0]   fid_r, bix_r;
  logic [5:0]    rs_r;
  logic [CW-1:0] scan_r, scan_nxt;
  logic          pend_r, pend_nxt;
  logic [CW-1:0] fresh_r, fresh_nxt;
  logic [IW-1:0] head_r, head_nxt, tail_r, tail_nxt;
  logic          empty_r, empty_nxt;
  logic [IW-1:0] tgt_r, tgt_nxt;
  bbc_pkg::op_kind_t kind_r, kind_nxt;

  logic [5:0]  res_slot_r, res_slot_nxt;
  logic [2:0]  res_status_r, res_status_nxt;
  logic [15:0] res_ref_r, res_ref_nxt;
  logic [31:0] res_ef_r, res_ef_nxt, res_ei_r, res_ei_nxt;

  logic [5:0]  out_slot_r;
  logic [2:0]  out_status_r;
  logic [15:0] out_ref_r;
  logic [31:0] out_ef_r, out_ei_r;

  logic [IW-1:0] rd_addr, rd_idx_q;
  logic [31:0]   tf_q, tb_q;
  logic [15:0]   ref_q;
  logic [IW-1:0] prev_q, next_q;

  logic          tag_we, ref_we, prev_we, next_we;
  logic [IW-1:0] tag_wa, ref_wa, prev_wa, next_wa, prev_wd, next_wd;
  logic [15:0]   ref_wd;

  logic [WW-1:0] rs_w;
  logic [15:0]   ref_dec;
  logic [IW+5:0] tgt_w, fresh_w;

  assign rs_w    = WW'(rs_r);
  assign ref_dec = ref_q - 16'd1;
  assign tgt_w   = {6'd0, tgt_r};
  assign fresh_w = {6'd0, fresh_r[IW-1:0]};

  assign rd_addr = cmd.scan ? scan_r[IW-1:0] : tgt_r;

  assign sts.is_rel      = cmd_r;
  assign sts.rel_bad     = (rs_w >= WW'(SLOTS)) || (rs_w >= WW'(fresh_r));
  assign sts.scan_more   = (scan_r < fresh_r);
  assign sts.pend        = pend_r;
  assign sts.match       = pend_r && (tf_q == fid_r) && (tb_q == bix_r);
  assign sts.fresh_avail = (fresh_r < CW'(SLOTS));
  assign sts.list_empty  = empty_r;

  always_comb begin
    scan_nxt       = scan_r;
    pend_nxt       = pend_r;
    fresh_nxt      = fresh_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    empty_nxt      = empty_r;
    tgt_nxt        = tgt_r;
    kind_nxt       = kind_r;
    res_slot_nxt   = res_slot_r;
    res_status_nxt = res_status_r;
    res_ref_nxt    = res_ref_r;
    res_ef_nxt     = res_ef_r;
    res_ei_nxt     = res_ei_r;
    tag_we  = 1'b0;
    tag_wa  = tgt_r;
    ref_we  = 1'b0;
    ref_wa  = tgt_r;
    ref_wd  = 16'd1;
    prev_we = 1'b0;
    prev_wa = tgt_r;
    prev_wd = tgt_r;
    next_we = 1'b0;
    next_wa = tgt_r;
    next_wd = head_r;

    if (cmd.decode) begin
      scan_nxt   = '0;
      pend_nxt   = 1'b0;
      res_ef_nxt = '0;
      res_ei_nxt = '0;
      if (cmd_r) begin
        tgt_nxt        = rs_w[IW-1:0];
        kind_nxt       = bbc_pkg::OP_REL;
        res_slot_nxt   = rs_r;
        res_status_nxt = bbc_pkg::ST_REL_ERR;
        res_ref_nxt    = '0;
      end
    end

    if (cmd.scan) begin
      pend_nxt = (scan_r < fresh_r);
      if (scan_r < fresh_r) scan_nxt = scan_r + CW'(1);
    end

    if (cmd.hit) begin
      tgt_nxt  = rd_idx_q;
      kind_nxt = bbc_pkg::OP_HIT;
    end

    if (cmd.fresh) begin
      tag_we         = 1'b1;
      tag_wa         = fresh_r[IW-1:0];
      ref_we         = 1'b1;
      ref_wa         = fresh_r[IW-1:0];
      ref_wd         = 16'd1;
      fresh_nxt      = fresh_r + CW'(1);
      res_slot_nxt   = fresh_w[5:0];
      res_status_nxt = bbc_pkg::ST_FRESH;
      res_ref_nxt    = 16'd1;
    end

    if (cmd.full) begin
      res_slot_nxt   = '0;
      res_status_nxt = bbc_pkg::ST_EXHAUSTED;
      res_ref_nxt    = '0;
    end

    if (cmd.evict) begin
      tgt_nxt  = tail_r;
      kind_nxt = bbc_pkg::OP_EVICT;
    end

    if (cmd.exec) begin
      res_slot_nxt = tgt_w[5:0];
      case (kind_r)
        bbc_pkg::OP_REL: begin
          if (ref_q == 16'd0) begin
            res_status_nxt = bbc_pkg::ST_REL_ERR;
            res_ref_nxt    = '0;
          end else begin
            ref_we         = 1'b1;
            ref_wd         = ref_dec;
            res_status_nxt = bbc_pkg::ST_RELEASED;
            res_ref_nxt    = ref_dec;
            if (ref_dec == 16'd0) begin
              // join the list as most recent
              next_we = 1'b1;
              next_wa = tgt_r;
              next_wd = head_r;
              if (!empty_r) begin
                prev_we = 1'b1;
                prev_wa = head_r;
                prev_wd = tgt_r;
              end else begin
                tail_nxt = tgt_r;
              end
              head_nxt  = tgt_r;
              empty_nxt = 1'b0;
            end
          end
        end
        bbc_pkg::OP_HIT, bbc_pkg::OP_EVICT: begin
          if (kind_r == bbc_pkg::OP_HIT && ref_q == bbc_pkg::CNT_MAX) begin
            res_status_nxt = bbc_pkg::ST_SATURATED;
            res_ref_nxt    = ref_q;
          end else begin
            if (kind_r == bbc_pkg::OP_EVICT || ref_q == 16'd0) begin
              // unlink from the release list
              if (tgt_r == head_r) head_nxt = next_q;
              else begin
                next_we = 1'b1;
                next_wa = prev_q;
                next_wd = next_q;
              end
              if (tgt_r == tail_r) tail_nxt = prev_q;
              else begin
                prev_we = 1'b1;
                prev_wa = next_q;
                prev_wd = prev_q;
              end
              if (tgt_r == head_r && tgt_r == tail_r) empty_nxt = 1'b1;
            end
            ref_we = 1'b1;
            if (kind_r == bbc_pkg::OP_EVICT) begin
              tag_we         = 1'b1;
              tag_wa         = tgt_r;
              ref_wd         = 16'd1;
              res_status_nxt = bbc_pkg::ST_EVICT;
              res_ref_nxt    = 16'd1;
              res_ef_nxt     = tf_q;
              res_ei_nxt     = tb_q;
            end else begin
              ref_wd         = ref_q + 16'd1;
              res_status_nxt = bbc_pkg::ST_HIT;
              res_ref_nxt    = ref_q + 16'd1;
            end
          end
        end
        default: res_status_nxt = bbc_pkg::ST_REL_ERR;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    tf_q     <= tag_file_mem[rd_addr];
    tb_q     <= tag_block_mem[rd_addr];
    ref_q    <= ref_mem[rd_addr];
    prev_q   <= prev_mem[rd_addr];
    next_q   <= next_mem[rd_addr];
    rd_idx_q <= rd_addr;
    if (tag_we) begin
      tag_file_mem[tag_wa]  <= fid_r;
      tag_block_mem[tag_wa] <= bix_r;
    end
    if (ref_we) ref_mem[ref_wa] <= ref_wd;
    if (prev_we) prev_mem[prev_wa] <= prev_wd;
    if (next_we) next_mem[next_wa] <= next_wd;
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cmd_r <= in_command;
      fid_r <= in_file_id;
      bix_r <= in_block_index;
      rs_r  <= in_release_slot;
    end
    tgt_r        <= tgt_nxt;
    kind_r       <= kind_nxt;
    res_slot_r   <= res_slot_nxt;
    res_status_r <= res_status_nxt;
    res_ref_r    <= res_ref_nxt;
    res_ef_r     <= res_ef_nxt;
    res_ei_r     <= res_ei_nxt;
    if (cmd.out_load) begin
      out_slot_r   <= res_slot_r;
      out_status_r <= res_status_r;
      out_ref_r    <= res_ref_r;
      out_ef_r     <= res_ef_r;
      out_ei_r     <= res_ei_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_r  <= '0;
      pend_r  <= 1'b0;
      fresh_r <= '0;
      head_r  <= '0;
      tail_r  <= '0;
      empty_r <= 1'b1;
    end else begin
      scan_r  <= scan_nxt;
      pend_r  <= pend_nxt;
      fresh_r <= fresh_nxt;
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      empty_r <= empty_nxt;
    end
  end

  assign out_slot          = out_slot_r;
  assign out_status        = out_status_r;
  assign out_ref_after     = out_ref_r;
  assign out_evicted_file  = out_ef_r;
  assign out_evicted_index = out_ei_r;

endmodule

// ----- tb/bbc_tb_pkg.sv -----
// Command codes shared by the buffer cache testbench files.
package bbc_tb_pkg;

  localparam logic CMD_ACQUIRE = 1'b0;
  localparam logic CMD_RELEASE = 1'b1;

endpackage

// ----- tb/bbc_lru_checker.sv -----
// Buffer pool tracker: predicts each result of the tag manager and compares it.
module bbc_lru_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic        in_command,
  input  logic [31:0] in_file_id,
  input  logic [31:0] in_block_index,
  input  logic [5:0]  in_release_slot,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [5:0]  out_slot,
  input  logic [2:0]  out_status,
  input  logic [15:0] out_ref_after,
  input  logic [31:0] out_evicted_file,
  input  logic [31:0] out_evicted_index,
  output int          fail_count,
  output int          pending
);

  localparam int NSLOTS = 64;

  typedef struct packed {
    logic [5:0]  slot;
    logic [2:0]  status;
    logic [15:0] ref_after;
    logic [31:0] ev_file;
    logic [31:0] ev_index;
  } buf_result_t;

  logic [31:0] pool_file [NSLOTS];
  logic [31:0] pool_block [NSLOTS];
  bit          pool_valid [NSLOTS];
  logic [15:0] pool_refs [NSLOTS];
  int unsigned free_rank [NSLOTS];  // 0 = not free, 1 = most recently freed
  int unsigned fresh_ptr;

  buf_result_t result_q[$];

  initial begin
    fail_count = 0;
    pending = 0;
    fresh_ptr = 0;
    for (int i = 0; i < NSLOTS; i++) begin
      pool_valid[i] = 0;
      pool_refs[i] = '0;
      free_rank[i] = 0;
    end
  end

  task automatic unlink_free(input int s);
    int unsigned r;
    r = free_rank[s];
    if (r != 0) begin
      for (int i = 0; i < NSLOTS; i++)
        if (free_rank[i] > r) free_rank[i]--;
      free_rank[s] = 0;
    end
  endtask

  task automatic push_free(input int s);
    for (int i = 0; i < NSLOTS; i++)
      if (free_rank[i] != 0) free_rank[i]++;
    free_rank[s] = 1;
  endtask

  task automatic predict_buffer_op(input logic cmd, input logic [31:0] fid,
                                   input logic [31:0] bix, input logic [5:0] rs);
    buf_result_t r;
    int victim;
    int unsigned best;
    bit found;
    r = '0;
    found = 0;
    if (cmd == bbc_tb_pkg::CMD_RELEASE) begin
      r.slot = rs;
      if (pool_refs[rs] == 0) begin
        r.status = bbc_pkg::ST_REL_ERR;
      end else begin
        pool_refs[rs]--;
        if (pool_refs[rs] == 0) push_free(rs);
        r.status = bbc_pkg::ST_RELEASED;
        r.ref_after = pool_refs[rs];
      end
    end else begin
      for (int i = 0; i < NSLOTS && !found; i++) begin
        if (pool_valid[i] && pool_file[i] == fid && pool_block[i] == bix) begin
          found = 1;
          r.slot = i[5:0];
          if (pool_refs[i] == bbc_pkg::CNT_MAX) begin
            r.status = bbc_pkg::ST_SATURATED;
          end else begin
            if (pool_refs[i] == 0) unlink_free(i);
            pool_refs[i]++;
            r.status = bbc_pkg::ST_HIT;
          end
          r.ref_after = pool_refs[i];
        end
      end
      if (!found && fresh_ptr < NSLOTS) begin
        victim = fresh_ptr;
        fresh_ptr++;
        pool_file[victim] = fid;
        pool_block[victim] = bix;
        pool_valid[victim] = 1;
        pool_refs[victim] = 16'd1;
        free_rank[victim] = 0;
        r.slot = victim[5:0];
        r.status = bbc_pkg::ST_FRESH;
        r.ref_after = 16'd1;
      end else if (!found) begin
        best = 0;
        victim = 0;
        for (int i = 0; i < NSLOTS; i++)
          if (free_rank[i] > best) begin
            best = free_rank[i];
            victim = i;
          end
        if (best == 0) begin
          r.status = bbc_pkg::ST_EXHAUSTED;
        end else begin
          r.ev_file = pool_file[victim];
          r.ev_index = pool_block[victim];
          unlink_free(victim);
          pool_file[victim] = fid;
          pool_block[victim] = bix;
          pool_refs[victim] = 16'd1;
          r.slot = victim[5:0];
          r.status = bbc_pkg::ST_EVICT;
          r.ref_after = 16'd1;
        end
      end
    end
    result_q.push_back(r);
  endtask

  task automatic report(input string what, input logic [31:0] got,
                        input logic [31:0] want);
    $display("MISMATCH %s: got %0h, expected %0h", what, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin
    buf_result_t e;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (result_q.size() == 0) begin
          report("unexpected result slot", 32'(out_slot), 32'd0);
        end else begin
          e = result_q.pop_front();
          if (out_slot !== e.slot) report("slot", 32'(out_slot), 32'(e.slot));
          if (out_status !== e.status)
            report("status", 32'(out_status), 32'(e.status));
          if (out_ref_after !== e.ref_after)
            report("ref_after", 32'(out_ref_after), 32'(e.ref_after));
          if (out_evicted_file !== e.ev_file)
            report("evicted_file", out_evicted_file, e.ev_file);
          if (out_evicted_index !== e.ev_index)
            report("evicted_index", out_evicted_index, e.ev_index);
        end
      end
      if (in_valid && !in_stall)
        predict_buffer_op(in_command, in_file_id, in_block_index, in_release_slot);
      pending = result_q.size();
    end
  end

endmodule

// ----- tb/block_buffer_cache_lru_core_tb.sv -----
// Stimulus and verdict for the buffer cache tag manager.
module block_buffer_cache_lru_core_tb;

  localparam int IDLE_LIMIT = 4000;
  localparam int RANDOM_ITEMS = 2000;
  localparam int NKEYS = 48;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic        in_command;
  logic [31:0] in_file_id;
  logic [31:0] in_block_index;
  logic [5:0]  in_release_slot;
  logic        out_valid;
  logic        out_stall;
  logic [5:0]  out_slot;
  logic [2:0]  out_status;
  logic [15:0] out_ref_after;
  logic [31:0] out_evicted_file;
  logic [31:0] out_evicted_index;
  int          fail_count;
  int          pending;

  bit          calm;
  int          stall_left;
  int          idle_cycles;
  logic [31:0] key_file [NKEYS];
  logic [31:0] key_block [NKEYS];

  block_buffer_cache_lru_core dut (.*);

  bbc_lru_checker checker_i (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // receiver stalls in random bursts
  always @(negedge clk) begin
    if (calm || !rst_n) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 5) == 0) begin
      out_stall <= 1'b1;
      stall_left <= $urandom_range(0, 4);
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send(input logic cmd, input logic [31:0] fid, input logic [31:0] bix,
                      input logic [5:0] rs);
    int gap;
    if (!calm && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 5);
      @(negedge clk);
      in_valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid = 1'b1;
    in_command = cmd;
    in_file_id = fid;
    in_block_index = bix;
    in_release_slot = rs;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic drain;
    @(negedge clk);
    in_valid = 1'b0;
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    int k;
    in_valid = 0;
    in_command = bbc_tb_pkg::CMD_ACQUIRE;
    in_file_id = '0;
    in_block_index = '0;
    in_release_slot = '0;
    out_stall = 0;
    stall_left = 0;
    idle_cycles = 0;
    calm = 0;
    rst_n = 0;
    for (int i = 0; i < NKEYS; i++) begin
      key_file[i] = (i < 8) ? i : $urandom;
      key_block[i] = $urandom;
    end
    key_file[NKEYS-1] = '1;
    key_block[NKEYS-1] = '1;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // directed: zero-count releases, fresh slots, hits, release to zero
    send(bbc_tb_pkg::CMD_RELEASE, 32'd0, 32'd0, 6'd0);
    send(bbc_tb_pkg::CMD_ACQUIRE, 32'h0, 32'h0, 6'd0);
    send(bbc_tb_pkg::CMD_ACQUIRE, '1, '1, 6'd63);
    send(bbc_tb_pkg::CMD_ACQUIRE, 32'h0, 32'h0, 6'd0);
    send(bbc_tb_pkg::CMD_RELEASE, 32'd0, 32'd0, 6'd0);
    send(bbc_tb_pkg::CMD_RELEASE, 32'd0, 32'd0, 6'd0);
    send(bbc_tb_pkg::CMD_RELEASE, 32'd0, 32'd0, 6'd0);
    send(bbc_tb_pkg::CMD_RELEASE, 32'd0, 32'd0, 6'd63);
    drain();

    // fill the pool, reuse the freed buffer, then run out
    for (int i = 0; i < 62; i++)
      send(bbc_tb_pkg::CMD_ACQUIRE, 32'h8000_0000 | i, ~i, 6'd0);
    send(bbc_tb_pkg::CMD_ACQUIRE, 32'h5555_5555, 32'hAAAA_AAAA, 6'd0);
    send(bbc_tb_pkg::CMD_ACQUIRE, 32'hAAAA_AAAA, 32'h5555_5555, 6'd0);
    send(bbc_tb_pkg::CMD_RELEASE, 32'd0, 32'd0, 6'd2);
    send(bbc_tb_pkg::CMD_RELEASE, 32'd0, 32'd0, 6'd1);
    drain();

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == RANDOM_ITEMS - 200) calm = 1;
      if ($urandom_range(0, 99) < 50) begin
        send(bbc_tb_pkg::CMD_RELEASE, $urandom, $urandom, 6'($urandom_range(0, 63)));
      end else if ($urandom_range(0, 99) < 85) begin
        k = $urandom_range(0, NKEYS - 1);
        send(bbc_tb_pkg::CMD_ACQUIRE, key_file[k], key_block[k],
             6'($urandom_range(0, 63)));
      end else begin
        send(bbc_tb_pkg::CMD_ACQUIRE, $urandom, $urandom, 6'($urandom_range(0, 63)));
      end
    end
    drain();
    repeat (100) @(posedge clk);

    if (fail_count == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

// ----- sim.f -----
src/bbc_pkg.sv
src/bbc_ctrl.sv
src/bbc_dpath.sv
src/block_buffer_cache_lru_core.sv
tb/bbc_tb_pkg.sv
tb/bbc_lru_checker.sv
tb/block_buffer_cache_lru_core_tb.sv
